>>> rtl/mrr_pkg.sv
`timescale 1ns / 1ps

package mrr_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    // input selector codes
    localparam logic [1:0] MODE_REQUEST = 2'd0;
    localparam logic [1:0] MODE_RX_BYTE = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;

    // result kind and status codes
    localparam logic       KIND_TX        = 1'b0;
    localparam logic       KIND_REPORT    = 1'b1;
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

    // configuration register indexes
    localparam logic CFG_SCALE = 1'b0;
    localparam logic CFG_RETRY = 1'b1;

    localparam logic signed [31:0] SCALE_RESET = 32'sd65536;
    localparam logic [1:0]         RETRY_RESET = 2'd2;

    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [15:0] REG_COUNT         = 16'h0001;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [2:0]  RX_FRAME_LEN      = 3'd7;
    localparam logic [2:0]  RX_CRC_BYTES      = 3'd5;

    typedef enum logic [1:0] {
        CMD_REQUEST,
        CMD_REPORT_OK,
        CMD_REPORT_CRC,
        CMD_REPORT_TIMEOUT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  slave;
        logic [15:0] reg_addr;
        logic [15:0] raw;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // CRC-16/MODBUS, one byte, reflected
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/modbus_rtu_read_register_master.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                Payload
// s_axis    in   s_tvalid / s_tready      tuser mode, tdata slave/register/rx byte
// m_axis    out  m_tvalid / m_tready      tuser kind, tlast, tdata byte/status/values
// cfg       in   cfg_we (no wait)         cfg_index, cfg_data
//
// One input item is accepted per cycle while the command queue has room.
// A read request yields 8 byte transfers, counted by the back end's byte
// counter; a report passes through the multiplier into the output register.
// Reset clears the receive state, the queue and the output valid flag.
// An output stall fills the queue; s_tready drops only when it is full.

module modbus_rtu_read_register_master
    import mrr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // slave_address[7:0], register_address[23:8], rx_byte[31:24]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // tx_byte[7:0], status[9:8], raw_value[25:10],
                                   // scaled_value[73:26], zero[79:74]
    output logic        m_tuser,   // kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic signed [31:0] scale_reg;
    logic [1:0]         retry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            retry_reg <= RETRY_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SCALE)
                scale_reg <= $signed(cfg_data);
            if (cfg_index == CFG_RETRY)
                retry_reg <= cfg_data[1:0];
        end
    end

    logic          s_accept;
    logic          q_push, q_pop;
    cmd_t          q_in, q_head;
    queue_status_t q_stat;

    logic               o_kind, o_last;
    logic [7:0]         o_tx;
    logic [1:0]         o_status;
    logic signed [15:0] o_raw;
    logic signed [47:0] o_scaled;

    assign s_tready = !q_stat.full;
    assign s_accept = s_tvalid && s_tready;

    mrr_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (s_accept),
        .mode             (s_tuser),
        .slave_address    (s_tdata[7:0]),
        .register_address (s_tdata[23:8]),
        .rx_byte          (s_tdata[31:24]),
        .retry_limit      (retry_reg),
        .push             (q_push),
        .cmd              (q_in)
    );

    mrr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .pop      (q_pop),
        .head     (q_head),
        .status   (q_stat)
    );

    mrr_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (q_head),
        .head_valid        (!q_stat.empty),
        .pop               (q_pop),
        .scale_coefficient (scale_reg),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .kind              (o_kind),
        .tx_byte           (o_tx),
        .last              (o_last),
        .status            (o_status),
        .raw_value         (o_raw),
        .scaled_value      (o_scaled)
    );

    assign m_tdata = {6'b000000, o_scaled, o_raw, o_status, o_tx};
    assign m_tuser = o_kind;
    assign m_tlast = o_last;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("command queue overflow");

    a_request_queued: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_tuser == MODE_REQUEST |=> !q_stat.empty)
        else $error("accepted request not queued");

    a_report_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tlast && m_tdata[7:0] == 8'h00)
        else $error("report carries frame byte fields");

endmodule

>>> rtl/mrr_front.sv
`timescale 1ns / 1ps

module mrr_front
    import mrr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [1:0]    mode,
    input  logic [7:0]    slave_address,
    input  logic [15:0]   register_address,
    input  logic [7:0]    rx_byte,
    input  logic [1:0]    retry_limit,
    output logic          push,
    output cmd_t          cmd
);

    logic [2:0]  rx_count_reg, rx_count_next;
    logic [15:0] crc_reg, crc_next;
    logic [1:0]  retries_reg, retries_next;
    logic        awaiting_reg, awaiting_next;
    logic [7:0]  rx3_reg, rx4_reg, rx5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg <= '0;
            crc_reg      <= CRC_INIT;
            retries_reg  <= '0;
            awaiting_reg <= 1'b0;
        end
        else
        begin
            rx_count_reg <= rx_count_next;
            crc_reg      <= crc_next;
            retries_reg  <= retries_next;
            awaiting_reg <= awaiting_next;
        end
    end

    // reply payload bytes; only read after being written in the current reply
    always_ff @(posedge clk)
    begin
        if (accept && mode == MODE_RX_BYTE && awaiting_reg)
        begin
            if (rx_count_reg == 3'd3)
                rx3_reg <= rx_byte;
            if (rx_count_reg == 3'd4)
                rx4_reg <= rx_byte;
            if (rx_count_reg == 3'd5)
                rx5_reg <= rx_byte;
        end
    end

    always_comb
    begin
        rx_count_next = rx_count_reg;
        crc_next      = crc_reg;
        retries_next  = retries_reg;
        awaiting_next = awaiting_reg;
        push          = 1'b0;
        cmd.kind      = CMD_REQUEST;
        cmd.slave     = slave_address;
        cmd.reg_addr  = register_address;
        cmd.raw       = {rx3_reg, rx4_reg};
        if (accept)
        begin
            case (mode)
                MODE_REQUEST:
                begin
                    push          = 1'b1;
                    rx_count_next = '0;
                    crc_next      = CRC_INIT;
                    retries_next  = retry_limit;
                    awaiting_next = 1'b1;
                end
                MODE_RX_BYTE:
                begin
                    if (awaiting_reg && rx_count_reg < RX_FRAME_LEN)
                    begin
                        if (rx_count_reg < RX_CRC_BYTES)
                            crc_next = crc_byte(crc_reg, rx_byte);
                        rx_count_next = rx_count_reg + 3'd1;
                        if (rx_count_next == RX_FRAME_LEN)
                        begin
                            awaiting_next = 1'b0;
                            push          = 1'b1;
                            // crc is final after byte 4; this byte is the crc high byte
                            cmd.kind = (crc_reg == {rx_byte, rx5_reg}) ? CMD_REPORT_OK
                                                                       : CMD_REPORT_CRC;
                        end
                    end
                end
                MODE_TIMEOUT:
                begin
                    if (awaiting_reg)
                    begin
                        if (retries_reg != 2'd0)
                            retries_next = retries_reg - 2'd1;
                        else
                        begin
                            awaiting_next = 1'b0;
                            push          = 1'b1;
                            cmd.kind      = CMD_REPORT_TIMEOUT;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

>>> rtl/mrr_queue.sv
`timescale 1ns / 1ps

module mrr_queue
    import mrr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cmd_t          push_cmd,
    input  logic          pop,
    output cmd_t          head,
    output queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

>>> rtl/mrr_back.sv
`timescale 1ns / 1ps

module mrr_back
    import mrr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                head,
    input  logic                head_valid,
    output logic                pop,
    input  logic signed [31:0]  scale_coefficient,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                kind,
    output logic [7:0]          tx_byte,
    output logic                last,
    output logic [1:0]          status,
    output logic signed [15:0]  raw_value,
    output logic signed [47:0]  scaled_value
);

    logic               valid_reg;
    logic [2:0]         idx_reg;
    logic [15:0]        crc_reg;
    logic               kind_reg, last_reg;
    logic [7:0]         tx_reg;
    logic [1:0]         status_reg;
    logic signed [15:0] raw_reg;
    logic signed [47:0] scaled_reg;

    logic               load, take;
    logic [7:0]         frame_byte;
    logic signed [47:0] product;

    assign load = !valid_reg || out_ready;
    assign take = load && head_valid;
    // a request stays at the head until its eighth byte is loaded
    assign pop  = take && (head.kind != CMD_REQUEST || idx_reg == 3'd7);

    always_comb
    begin
        case (idx_reg)
            3'd0:    frame_byte = head.slave;
            3'd1:    frame_byte = FUNC_READ_HOLDING;
            3'd2:    frame_byte = head.reg_addr[15:8];
            3'd3:    frame_byte = head.reg_addr[7:0];
            3'd4:    frame_byte = REG_COUNT[15:8];
            3'd5:    frame_byte = REG_COUNT[7:0];
            3'd6:    frame_byte = crc_reg[7:0];
            3'd7:    frame_byte = crc_reg[15:8];
            default: frame_byte = 8'h00;
        endcase
    end

    assign product = 48'($signed(head.raw)) * 48'(scale_coefficient);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= head_valid;
            if (head_valid && head.kind == CMD_REQUEST)
                idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            case (head.kind)
                CMD_REQUEST:
                begin
                    kind_reg   <= KIND_TX;
                    tx_reg     <= frame_byte;
                    last_reg   <= (idx_reg == 3'd7);
                    status_reg <= STATUS_OK;
                    raw_reg    <= '0;
                    scaled_reg <= '0;
                    if (idx_reg < 3'd6)
                        crc_reg <= crc_byte((idx_reg == 3'd0) ? CRC_INIT : crc_reg, frame_byte);
                end
                CMD_REPORT_OK:
                begin
                    kind_reg   <= KIND_REPORT;
                    tx_reg     <= 8'h00;
                    last_reg   <= 1'b0;
                    status_reg <= STATUS_OK;
                    raw_reg    <= $signed(head.raw);
                    scaled_reg <= product;
                end
                CMD_REPORT_CRC:
                begin
                    kind_reg   <= KIND_REPORT;
                    tx_reg     <= 8'h00;
                    last_reg   <= 1'b0;
                    status_reg <= STATUS_CRC_ERR;
                    raw_reg    <= '0;
                    scaled_reg <= '0;
                end
                default:
                begin
                    kind_reg   <= KIND_REPORT;
                    tx_reg     <= 8'h00;
                    last_reg   <= 1'b0;
                    status_reg <= STATUS_TIMEOUT;
                    raw_reg    <= '0;
                    scaled_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid    = valid_reg;
    assign kind         = kind_reg;
    assign tx_byte      = tx_reg;
    assign last         = last_reg;
    assign status       = status_reg;
    assign raw_value    = raw_reg;
    assign scaled_value = scaled_reg;

endmodule

>>> tb/modbus_rtu_read_register_master_tb.sv
`timescale 1ns / 1ps

module modbus_rtu_read_register_master_tb;
    import mrr_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_PRINTS    = 100;

    // the package defines no name for the unused selector value
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [1:0]  status;
        logic [15:0] raw_value;
        logic [47:0] scaled_value;
    } master_out_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = MODE_REQUEST;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = CFG_SCALE;
    logic [31:0] cfg_data  = '0;

    // predictor copy of the master
    logic signed [31:0] scale_q16;
    logic [1:0]         retry_setting;
    logic [7:0]         reply_buf [7];
    int                 reply_len;
    logic [15:0]        reply_crc;
    logic [1:0]         retries_left;
    logic               reply_pending;

    master_out_t expected_out [$];
    master_out_t head;
    int          errors     = 0;
    int          cycles     = 0;
    int          items_sent = 0;
    bit          steady     = 1'b0;

    modbus_rtu_read_register_master dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        repeat (8)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic void master_step(logic [1:0] mode, logic [7:0] slave,
                                        logic [15:0] reg_addr, logic [7:0] rx_byte);
        logic [7:0]         frame [8];
        logic [15:0]        crc;
        logic signed [47:0] product;
        case (mode)
            MODE_REQUEST:
            begin
                frame[0] = slave;
                frame[1] = FUNC_READ_HOLDING;
                frame[2] = reg_addr[15:8];
                frame[3] = reg_addr[7:0];
                frame[4] = REG_COUNT[15:8];
                frame[5] = REG_COUNT[7:0];
                crc = CRC_INIT;
                for (int i = 0; i < 6; i++)
                    crc = crc16_update(crc, frame[i]);
                frame[6] = crc[7:0];
                frame[7] = crc[15:8];
                for (int i = 0; i < 8; i++)
                    expected_out.push_back('{KIND_TX, frame[i], i == 7, STATUS_OK,
                                             16'h0, 48'h0});
                reply_len     = 0;
                reply_crc     = CRC_INIT;
                retries_left  = retry_setting;
                reply_pending = 1'b1;
            end
            MODE_RX_BYTE:
            begin
                if (reply_pending && reply_len < 7)
                begin
                    reply_buf[reply_len] = rx_byte;
                    if (reply_len < 5)
                        reply_crc = crc16_update(reply_crc, rx_byte);
                    reply_len++;
                    if (reply_len == 7)
                    begin
                        reply_pending = 1'b0;
                        if (reply_buf[5] != reply_crc[7:0] || reply_buf[6] != reply_crc[15:8])
                            expected_out.push_back('{KIND_REPORT, 8'h00, 1'b0, STATUS_CRC_ERR,
                                                     16'h0, 48'h0});
                        else
                        begin
                            product = $signed({reply_buf[3], reply_buf[4]}) * scale_q16;
                            expected_out.push_back('{KIND_REPORT, 8'h00, 1'b0, STATUS_OK,
                                                     {reply_buf[3], reply_buf[4]}, product});
                        end
                    end
                end
            end
            MODE_TIMEOUT:
            begin
                if (reply_pending)
                begin
                    if (retries_left > 0)
                        retries_left--;
                    else
                    begin
                        reply_pending = 1'b0;
                        expected_out.push_back('{KIND_REPORT, 8'h00, 1'b0, STATUS_TIMEOUT,
                                                 16'h0, 48'h0});
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (errors < MAX_PRINTS)
            $display("mismatch %s: got %0h, expected %0h, at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // output side: random stalls, and every transfer compared with the oldest expectation
    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 34);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_out.size() == 0)
                report_mismatch("transfer with nothing expected", m_tdata[63:0], 64'h0);
            else
            begin
                head = expected_out.pop_front();
                if (m_tuser !== head.kind)
                    report_mismatch("kind", m_tuser, head.kind);
                if (m_tdata[7:0] !== head.tx_byte)
                    report_mismatch("tx_byte", m_tdata[7:0], head.tx_byte);
                if (m_tlast !== head.last)
                    report_mismatch("last", m_tlast, head.last);
                if (m_tdata[9:8] !== head.status)
                    report_mismatch("status", m_tdata[9:8], head.status);
                if (m_tdata[25:10] !== head.raw_value)
                    report_mismatch("raw_value", m_tdata[25:10], head.raw_value);
                if (m_tdata[73:26] !== head.scaled_value)
                    report_mismatch("scaled_value", m_tdata[73:26], head.scaled_value);
            end
        end
    end

    task automatic send_item(logic [1:0] mode, logic [7:0] slave, logic [15:0] reg_addr,
                             logic [7:0] rx_byte);
        if (!steady && $urandom_range(99) < 25)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {rx_byte, reg_addr, slave};
        do
            @(posedge clk);
        while (!s_tready);
        master_step(mode, slave, reg_addr, rx_byte);
        items_sent++;
    endtask

    task automatic send_request(logic [7:0] slave, logic [15:0] reg_addr);
        send_item(MODE_REQUEST, slave, reg_addr, 8'($urandom));
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(MODE_RX_BYTE, 8'($urandom), 16'($urandom), b);
    endtask

    task automatic send_timeout();
        send_item(MODE_TIMEOUT, 8'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // first nbytes of a reply carrying value; id, function and count are not checked
    task automatic send_reply(logic [15:0] value, bit corrupt, int nbytes);
        logic [7:0]  b [7];
        logic [15:0] crc;
        int          k;
        b[0] = 8'($urandom);
        b[1] = ($urandom_range(3) == 0) ? 8'($urandom) : FUNC_READ_HOLDING;
        b[2] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h02;
        b[3] = value[15:8];
        b[4] = value[7:0];
        crc = CRC_INIT;
        for (int i = 0; i < 5; i++)
            crc = crc16_update(crc, b[i]);
        b[5] = crc[7:0];
        b[6] = crc[15:8];
        if (corrupt)
        begin
            k = $urandom_range(6);
            b[k] = b[k] ^ (8'd1 << $urandom_range(7));
        end
        for (int i = 0; i < nbytes; i++)
            send_byte(b[i]);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(logic index, logic [31:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == CFG_SCALE)
            scale_q16 = value;
        else
            retry_setting = value[1:0];
    endtask

    // complete request/reply exchanges, corrupted, broken and abandoned exchanges, and noise
    task automatic run_traffic(int n);
        int stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    send_request(8'($urandom), 16'($urandom));
                    send_reply(pick_value(), 1'b0, 7);
                    if ($urandom_range(3) == 0)
                        send_byte(8'($urandom));
                end
                4:
                begin
                    send_request(8'($urandom), 16'($urandom));
                    send_reply(pick_value(), 1'b1, 7);
                end
                5, 6:
                begin
                    send_request(8'($urandom), 16'($urandom));
                    send_reply(pick_value(), 1'b0, $urandom_range(6));
                    repeat ($urandom_range(1, 4)) send_timeout();
                end
                7:
                begin
                    // abandoned reply, restarted by whatever request comes next
                    send_request(8'($urandom), 16'($urandom));
                    send_reply(pick_value(), 1'b0, $urandom_range(1, 6));
                end
                default:
                    send_item(2'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
            endcase
        end
    endtask

    task automatic test_ignored_items();
        send_item(MODE_UNUSED, 8'hFF, 16'hFFFF, 8'hFF);
        send_byte(8'h5A);
        send_timeout();
    endtask

    task automatic test_default_read();
        send_request(8'hFF, 16'hFFFF);
        send_reply(16'h8000, 1'b0, 7);
        send_byte(8'hFF);
    endtask

    task automatic test_restart_and_timeout();
        send_request(8'h00, 16'h0000);
        send_reply(16'h7FFF, 1'b0, 2);
        send_request(8'hA5, 16'h1234);
        repeat (3) send_timeout();
    endtask

    task automatic test_crc_error();
        send_request(8'h11, 16'h00FF);
        send_reply(16'h7FFF, 1'b1, 7);
    endtask

    task automatic test_config_sweep();
        logic [31:0] scale_set [6];
        logic [1:0]  retry_set [6];
        scale_set = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h0};
        retry_set = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0};
        scale_set[5] = $urandom;
        retry_set[5] = 2'($urandom);
        for (int i = 0; i < 6; i++)
        begin
            write_config(CFG_SCALE, scale_set[i]);
            write_config(CFG_RETRY, {30'h0, retry_set[i]});
            run_traffic(60);
        end
    endtask

    task automatic test_steady_stream();
        wait_drained();
        steady = 1'b1;
        run_traffic(80);
        wait_drained();
        steady = 1'b0;
    endtask

    initial
    begin
        scale_q16     = SCALE_RESET;
        retry_setting = RETRY_RESET;
        reply_len     = 0;
        reply_crc     = CRC_INIT;
        retries_left  = 2'd0;
        reply_pending = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_ignored_items();
        test_default_read();
        test_restart_and_timeout();
        test_crc_error();
        test_config_sweep();
        test_steady_stream();

        wait_drained();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
rtl/mrr_pkg.sv
rtl/mrr_front.sv
rtl/mrr_queue.sv
rtl/mrr_back.sv
rtl/modbus_rtu_read_register_master.sv
tb/modbus_rtu_read_register_master_tb.sv
